@@ hw/rtl/four_class_ratio_scheduler_core_defines.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef FOUR_CLASS_RATIO_SCHEDULER_CORE_DEFINES_SVH
`define FOUR_CLASS_RATIO_SCHEDULER_CORE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define FCRS_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define FCRS_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FCRS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/fcrs_pkg.sv @@
// Shared types, codes and defaults of the four-class ratio scheduler.
package fcrs_pkg;

  localparam int DEF_FIFO_DEPTH    = 16;
  localparam int DEF_HANDLE_WIDTH  = 16;
  localparam int DEF_COUNTER_WIDTH = 32;

  localparam int HANDLE_W = 16;
  localparam int OCC_W    = 7;
  localparam int RATIO_W  = 8;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd8;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic [1:0] CLASS_MAX    = 2'd0;
  localparam logic [1:0] CLASS_HIGH   = 2'd1;
  localparam logic [1:0] CLASS_NORMAL = 2'd2;
  localparam logic [1:0] CLASS_LOW    = 2'd3;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                operation;
    logic [1:0]          priority_class;
    logic [HANDLE_W-1:0] item_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] served_handle;
    logic [1:0]          served_class;
    logic [OCC_W-1:0]    total_occupancy;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;
    logic mul1;
    logic mul2;
    logic commit;
    logic load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic req_dequeue;
    logic out_busy;
  } sts_t;

endpackage

@@ hw/rtl/four_class_ratio_scheduler_core.sv @@
// Top level of the four-class ratio scheduler: controller plus datapath.
// An enqueue beat passes the commit and load states; a dequeue beat first passes the two
//   registered multiplier stages for the ratio compares. The handle memory read is registered.
//   No new beat is taken until the result is loaded, which waits while the response stalls.
// Reset (rst, synchronous): all classes empty, counters zero, share ratio 8, no
//   result pending; handle storage is not cleared and needs no clearing pass.
module four_class_ratio_scheduler_core #(
  parameter int FIFO_DEPTH    = fcrs_pkg::DEF_FIFO_DEPTH,
  parameter int HANDLE_WIDTH  = fcrs_pkg::DEF_HANDLE_WIDTH,
  parameter int COUNTER_WIDTH = fcrs_pkg::DEF_COUNTER_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration: share ratio, written while idle.
  input  logic                         cfg_we,
  input  logic [fcrs_pkg::RATIO_W-1:0] cfg_data,
  // Request channel.
  input  logic                         req_valid,
  output logic                         req_ready,
  input  fcrs_pkg::req_t               req,
  // Response channel.
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output fcrs_pkg::rsp_t               rsp
);
  import fcrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: accepts one beat, steps through the multiply stages on a
  // dequeue, commits the queue update and holds until the result register
  // frees up.
  fcrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: per-class queues in one memory, occupancy and dequeue counters,
  // ratio products, and the result register that decouples the response side.
  fcrs_dpath #(
    .FIFO_DEPTH    (FIFO_DEPTH),
    .HANDLE_WIDTH  (HANDLE_WIDTH),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule

@@ hw/rtl/fcrs_ctrl.sv @@
// Sequencing state machine of the four-class ratio scheduler.
`include "four_class_ratio_scheduler_core_defines.svh"

module fcrs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  fcrs_pkg::sts_t sts,
  output fcrs_pkg::cmd_t cmd
);
  import fcrs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_COMMIT,
    S_LOAD
  } state_t;

  state_t state;
  logic   take;

  assign take = req_valid && req_ready;

  always_comb begin
    cmd.take   = take;
    cmd.mul1   = (state == S_MUL1);
    cmd.mul2   = (state == S_MUL2);
    cmd.commit = (state == S_COMMIT);
    cmd.load   = (state == S_LOAD) && !sts.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            req_ready <= 1'b0;
            state     <= sts.req_dequeue ? S_MUL1 : S_COMMIT;
          end
        end
        S_MUL1:   state <= S_MUL2;
        S_MUL2:   state <= S_COMMIT;
        S_COMMIT: state <= S_LOAD;
        S_LOAD: begin
          if (!sts.out_busy) begin
            state     <= S_IDLE;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          req_ready <= 1'b1;
        end
      endcase
    end
  end

  `FCRS_CHECK(a_cmd_onehot, $onehot0({cmd.take, cmd.mul1, cmd.mul2, cmd.commit, cmd.load}), "fcrs_ctrl: overlapping commands")
  `FCRS_IMPLY(a_ready_idle, req_ready, state == S_IDLE, "fcrs_ctrl: ready outside idle")
  `FCRS_NEXT(a_commit_load, cmd.commit, state == S_LOAD, "fcrs_ctrl: commit not followed by load")

endmodule

@@ hw/rtl/fcrs_dpath.sv @@
// Queue storage, counters, ratio compares and result register of the scheduler.
`include "four_class_ratio_scheduler_core_defines.svh"

module fcrs_dpath #(
  parameter int FIFO_DEPTH    = fcrs_pkg::DEF_FIFO_DEPTH,
  parameter int HANDLE_WIDTH  = fcrs_pkg::DEF_HANDLE_WIDTH,
  parameter int COUNTER_WIDTH = fcrs_pkg::DEF_COUNTER_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [fcrs_pkg::RATIO_W-1:0] cfg_data,
  input  fcrs_pkg::req_t               req,
  input  fcrs_pkg::cmd_t               cmd,
  output fcrs_pkg::sts_t               sts,
  output fcrs_pkg::rsp_t               rsp,
  output logic                         rsp_valid,
  input  logic                         rsp_ready
);
  import fcrs_pkg::*;

  localparam int PW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNTW  = $clog2(FIFO_DEPTH + 1);
  localparam int AW    = PW + 2;
  localparam int CW    = COUNTER_WIDTH;
  localparam int PA_W  = CW + 1 + RATIO_W;
  localparam int PC_W  = PA_W + RATIO_W;
  localparam int TW0   = $clog2(4 * FIFO_DEPTH + 1);
  localparam int TOT_W = (TW0 > OCC_W) ? TW0 : OCC_W;
  localparam logic [PW-1:0]   LAST_POS = PW'(FIFO_DEPTH - 1);
  localparam logic [CNTW-1:0] DEPTH_C  = CNTW'(FIFO_DEPTH);

  logic [HANDLE_WIDTH-1:0] mem [0:(1 << AW) - 1];
  logic [HANDLE_WIDTH-1:0] rd_data;

  req_t             item;
  logic [RATIO_W-1:0] ratio;
  logic [RATIO_W-1:0] r_eff;
  logic [PW-1:0]    head  [4];
  logic [CNTW-1:0]  count [4];
  logic [CW-1:0]    dqc   [4];
  logic [TOT_W-1:0] total;
  logic [PA_W-1:0]  pa;
  logic [PA_W-1:0]  pb;
  logic [PC_W-1:0]  pc;

  logic [1:0] res_status;
  logic [1:0] res_class;
  logic       res_hit;

  logic [3:0]  has;
  logic        hi_ok;
  logic        low_turn;
  logic        pick_hit;
  logic [1:0]  pick;
  logic [1:0]  sel;
  logic        is_deq;
  logic        full;
  logic [CNTW:0] tail_sum;
  logic [PW-1:0] tail;
  logic [PW-1:0] head_next;
  logic [CW:0]   c2p1;
  logic [CW:0]   c3p1;

  assign r_eff = (ratio == '0) ? RATIO_W'(1) : ratio;
  assign c2p1  = {1'b0, dqc[2]} + (CW + 1)'(1);
  assign c3p1  = {1'b0, dqc[3]} + (CW + 1)'(1);

  assign sts.req_dequeue = (req.operation == OP_DEQUEUE);
  assign sts.out_busy    = rsp_valid && !rsp_ready;

  // Class selection; the divides of the counters by the ratio are replaced by
  // products of the compared counter plus one with the ratio.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      has[i] = (count[i] != '0);
    end
    hi_ok    = (PA_W'(dqc[1]) < pa) && (PC_W'(dqc[1]) < pc);
    low_turn = (pb <= PA_W'(dqc[2]));
    pick_hit = 1'b1;
    pick     = CLASS_MAX;
    if (has[0]) begin
      pick = CLASS_MAX;
    end else if (has[1] && !has[2] && !has[3]) begin
      pick = CLASS_HIGH;
    end else if (has[1] && hi_ok) begin
      pick = CLASS_HIGH;
    end else if (has[2] && !has[3]) begin
      pick = CLASS_NORMAL;
    end else if (!has[2] && has[3]) begin
      pick = CLASS_LOW;
    end else if (has[2] && has[3]) begin
      pick = low_turn ? CLASS_LOW : CLASS_NORMAL;
    end else begin
      pick_hit = 1'b0;
    end
  end

  always_comb begin
    is_deq    = (item.operation == OP_DEQUEUE);
    sel       = is_deq ? pick : item.priority_class;
    full      = (count[sel] >= DEPTH_C);
    tail_sum  = (CNTW + 1)'(head[sel]) + (CNTW + 1)'(count[sel]);
    tail      = (tail_sum >= (CNTW + 1)'(FIFO_DEPTH))
              ? PW'(tail_sum - (CNTW + 1)'(FIFO_DEPTH))
              : PW'(tail_sum);
    head_next = (head[sel] == LAST_POS) ? '0 : head[sel] + PW'(1);
  end

  // Control and counter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= RATIO_RESET;
      total <= '0;
      for (int i = 0; i < 4; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
        dqc[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        ratio <= cfg_data;
      end
      if (cmd.commit) begin
        if (is_deq) begin
          if (pick_hit) begin
            head[sel]  <= head_next;
            count[sel] <= count[sel] - CNTW'(1);
            total      <= total - TOT_W'(1);
            if (!(&dqc[sel])) begin
              dqc[sel] <= dqc[sel] + CW'(1);
            end
          end
        end else if (!full) begin
          count[sel] <= count[sel] + CNTW'(1);
          total      <= total + TOT_W'(1);
        end
      end
    end
  end

  // Payload registers and ratio products.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= req;
    end
    if (cmd.mul1) begin
      pa <= PA_W'(c2p1) * PA_W'(r_eff);
      pb <= PA_W'(c3p1) * PA_W'(r_eff);
    end
    if (cmd.mul2) begin
      pc <= PC_W'(pb) * PC_W'(r_eff);
    end
    if (cmd.commit) begin
      res_hit   <= is_deq && pick_hit;
      res_class <= (is_deq && pick_hit) ? pick : CLASS_MAX;
      if (is_deq) begin
        res_status <= pick_hit ? STATUS_DONE : STATUS_EMPTY;
      end else begin
        res_status <= full ? STATUS_FULL : STATUS_DONE;
      end
    end
  end

  // Handle storage: each commit reads; a non-full enqueue also writes.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (!is_deq && !full) begin
        mem[{sel, tail}] <= HANDLE_WIDTH'(item.item_handle);
      end
      rd_data <= mem[{sel, head[sel]}];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.status          <= res_status;
      rsp.served_handle   <= res_hit ? HANDLE_W'(rd_data) : '0;
      rsp.served_class    <= res_class;
      rsp.total_occupancy <= total[OCC_W-1:0];
    end
  end

  `FCRS_CHECK(a_total_sum, total == TOT_W'(count[0]) + TOT_W'(count[1]) + TOT_W'(count[2]) + TOT_W'(count[3]), "fcrs_dpath: total occupancy out of step")
  `FCRS_CHECK(a_count_bound, (count[0] <= DEPTH_C) && (count[1] <= DEPTH_C) && (count[2] <= DEPTH_C) && (count[3] <= DEPTH_C), "fcrs_dpath: class count beyond depth")
  `FCRS_NEXT(a_load_valid, cmd.load, rsp_valid, "fcrs_dpath: loaded result not valid")

endmodule

@@ sim/tb_four_class_ratio_scheduler_core.sv @@
// Self-checking testbench for the four-class ratio scheduler core.
module tb_four_class_ratio_scheduler_core;
  import fcrs_pkg::*;

  localparam int DEPTH       = DEF_FIFO_DEPTH;
  localparam int CNT_W       = DEF_COUNTER_WIDTH;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_BEATS = 243;
  // Margin after the last response before the block is treated as idle.
  localparam int SETTLE_CYCLES = 8;

  // Shadow copy of the scheduler: four handle FIFOs, per-class dequeue
  // counters and the share ratio. Every accepted request beat is run through
  // it, and the response it predicts waits in order for the real one.
  class fair_share_tracker;
    logic [HANDLE_W-1:0] slots [4][DEPTH];
    int                  head [4];
    int                  fill [4];
    logic [CNT_W-1:0]    served [4];
    logic [RATIO_W-1:0]  ratio;
    rsp_t                pending [$];
    int                  errors;
    int                  checked;
    int                  full_drops;
    int                  empty_hits;
    int                  class_hits [4];

    function new();
      ratio = RATIO_RESET;
      errors = 0;
      checked = 0;
      full_drops = 0;
      empty_hits = 0;
      for (int c = 0; c < 4; c++) begin
        head[c] = 0;
        fill[c] = 0;
        served[c] = '0;
        class_hits[c] = 0;
      end
    endfunction

    function void set_ratio(logic [RATIO_W-1:0] v);
      ratio = v;
    endfunction

    // Apply one accepted request beat and queue the response it must cause.
    function void note_request(req_t r);
      rsp_t             e;
      logic [CNT_W-1:0] eff;
      logic [CNT_W-1:0] allow_n;
      logic [CNT_W-1:0] allow_l;
      logic [1:0]       c;
      int               pick;
      int               occ;
      bit               hi;
      bit               no;
      bit               lo;

      e = '0;
      e.status = STATUS_DONE;
      pick = -1;
      if (r.operation == OP_ENQUEUE) begin
        c = r.priority_class;
        if (fill[c] >= DEPTH) begin
          // Drop the handle: class FIFO is full, nothing changes.
          e.status = STATUS_FULL;
          full_drops++;
        end else begin
          slots[c][(head[c] + fill[c]) % DEPTH] = r.item_handle;
          fill[c]++;
        end
      end else begin
        // A ratio of zero behaves as one.
        eff = (ratio == '0) ? 1 : ratio;
        hi = fill[CLASS_HIGH] != 0;
        no = fill[CLASS_NORMAL] != 0;
        lo = fill[CLASS_LOW] != 0;
        if (fill[CLASS_MAX] != 0) begin
          pick = CLASS_MAX;
        end else if (hi && !no && !lo) begin
          pick = CLASS_HIGH;
        end else begin
          allow_n = served[CLASS_HIGH] / eff;
          allow_l = allow_n / eff;
          if (hi && served[CLASS_NORMAL] >= allow_n && served[CLASS_LOW] >= allow_l)
            pick = CLASS_HIGH;
          else if (no && !lo)
            pick = CLASS_NORMAL;
          else if (!no && lo)
            pick = CLASS_LOW;
          else if (no && lo)
            pick = (served[CLASS_LOW] < served[CLASS_NORMAL] / eff) ? CLASS_LOW : CLASS_NORMAL;
        end
        if (pick < 0) begin
          e.status = STATUS_EMPTY;
          empty_hits++;
        end else begin
          c = pick[1:0];
          e.served_handle = slots[c][head[c]];
          e.served_class = c;
          head[c] = (head[c] + 1) % DEPTH;
          fill[c]--;
          // Saturate the dequeue counter at all ones.
          if (served[c] != '1)
            served[c]++;
          class_hits[c]++;
        end
      end
      occ = fill[0] + fill[1] + fill[2] + fill[3];
      e.total_occupancy = occ[OCC_W-1:0];
      pending.push_back(e);
    endfunction

    // Compare one accepted response beat with the oldest prediction.
    function void check_response(rsp_t got);
      rsp_t e;

      if (pending.size() == 0) begin
        $display("%0t unexpected response: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.status !== e.status) begin
        $display("%0t status mismatch: expected %0d, actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.served_handle !== e.served_handle) begin
        $display("%0t served_handle mismatch: expected %h, actual %h",
                 $time, e.served_handle, got.served_handle);
        errors++;
      end
      if (got.served_class !== e.served_class) begin
        $display("%0t served_class mismatch: expected %0d, actual %0d",
                 $time, e.served_class, got.served_class);
        errors++;
      end
      if (got.total_occupancy !== e.total_occupancy) begin
        $display("%0t total_occupancy mismatch: expected %0d, actual %0d",
                 $time, e.total_occupancy, got.total_occupancy);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [RATIO_W-1:0] cfg_data = '0;
  logic               req_valid = 1'b0;
  logic               req_ready;
  req_t               req = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  rsp_t               rsp;

  fair_share_tracker  sb;
  // When set, neither side idles: back-to-back beats and an always-ready sink.
  bit                 quiet = 1'b0;

  four_class_ratio_scheduler_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a beat never comes back.
  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int w;

    if (quiet)
      return 0;
    w = $urandom_range(0, 99);
    if (w < 60)
      return 0;
    if (w < 88)
      return $urandom_range(1, 3);
    if (w < 97)
      return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic req_t make_req(logic op, logic [1:0] cls, logic [HANDLE_W-1:0] h);
    req_t r;

    r.operation = op;
    r.priority_class = cls;
    r.item_handle = h;
    return r;
  endfunction

  // Random beat: enq_pct sets the enqueue share, max class is kept rare so
  // the high/normal/low ratio logic gets most of the dequeues.
  function automatic req_t random_beat(int enq_pct);
    req_t r;
    int   w;

    r.operation = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
    w = $urandom_range(0, 99);
    if (w < 10)
      r.priority_class = CLASS_MAX;
    else if (w < 40)
      r.priority_class = CLASS_HIGH;
    else if (w < 70)
      r.priority_class = CLASS_NORMAL;
    else
      r.priority_class = CLASS_LOW;
    r.item_handle = HANDLE_W'($urandom);
    return r;
  endfunction

  // Hold the beat until accepted, record it, then idle for a random gap.
  // With no gap, valid stays high into the next beat.
  task automatic send_beat(req_t item);
    int gap;

    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_ready !== 1'b1);
    sb.note_request(item);
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted response has been taken,
  // then let the pipeline settle.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the share ratio only with the block idle.
  task automatic write_ratio(logic [RATIO_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_ratio(v);
  endtask

  // Response side: check accepted beats, stall at random between them.
  initial begin : rsp_side
    int stall;
    int w;

    stall = 0;
    forever begin
      @(posedge clk);
      if (rsp_valid === 1'b1 && rsp_ready)
        sb.check_response(rsp);
      if (stall == 0 && !quiet) begin
        w = $urandom_range(0, 99);
        if (w < 12)
          stall = $urandom_range(1, 3);
        else if (w < 14)
          stall = $urandom_range(10, 30);
      end
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        stall--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [RATIO_W-1:0] ratios [NUM_PHASES];
    int                 n;
    int                 burst;
    int                 enq_pct;
    int                 w;

    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at the reset ratio.
    // Dequeue with everything empty.
    send_beat(make_req(OP_DEQUEUE, CLASS_MAX, 16'hFFFF));
    // One beat into every class, extreme handles.
    send_beat(make_req(OP_ENQUEUE, CLASS_MAX, 16'hFFFF));
    send_beat(make_req(OP_ENQUEUE, CLASS_HIGH, 16'h0000));
    send_beat(make_req(OP_ENQUEUE, CLASS_NORMAL, 16'hA5A5));
    send_beat(make_req(OP_ENQUEUE, CLASS_LOW, 16'h5A5A));
    // Drain them: max first, then the fair-share order.
    repeat (4) send_beat(make_req(OP_DEQUEUE, CLASS_LOW, 16'h1234));
    // Fill the low FIFO, then overflow it once.
    for (int i = 0; i <= DEPTH; i++)
      send_beat(make_req(OP_ENQUEUE, CLASS_LOW, 16'(i * 16'h1111) ^ 16'h8001));

    // Random phases, one ratio each: the extremes, zero, small values,
    // the reset value and one random value.
    ratios[0] = 8'd1;
    ratios[1] = 8'd255;
    ratios[2] = 8'd0;
    ratios[3] = 8'd2;
    ratios[4] = RATIO_RESET;
    ratios[5] = 8'd3;
    ratios[6] = 8'($urandom_range(4, 254));
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_ratio(ratios[p]);
      quiet = (p == 3);
      n = 0;
      while (n < PHASE_BEATS) begin
        // Alternate fill-heavy, drain-heavy and balanced bursts so the
        // FIFOs swing between empty and full.
        w = $urandom_range(0, 2);
        enq_pct = (w == 0) ? 80 : (w == 1) ? 25 : 55;
        burst = $urandom_range(8, 40);
        for (int b = 0; b < burst && n < PHASE_BEATS; b++) begin
          send_beat(random_beat(enq_pct));
          n++;
        end
        // Now and then hold off until all responses are back.
        if ($urandom_range(0, 9) == 0)
          wait_drained();
      end
    end
    quiet = 1'b0;

    wait_drained();
    $display("tb: %0d responses checked over %0d ratio settings, %0d full drops, %0d empty dequeues",
             sb.checked, NUM_PHASES + 1, sb.full_drops, sb.empty_hits);
    $display("tb: served per class max/high/normal/low = %0d/%0d/%0d/%0d",
             sb.class_hits[0], sb.class_hits[1], sb.class_hits[2], sb.class_hits[3]);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
